// ===== sv/grid_split_search_defines.svh =====
// assertion macros for the checks in the top level
`ifndef GRID_SPLIT_SEARCH_DEFINES_SVH
`define GRID_SPLIT_SEARCH_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define GSS_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define GSS_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/gss_pkg.sv =====
package gss_pkg;

	// defaults for the top level parameters
	localparam int MAX_PROCS_DEF = 1024;
	localparam int GRID_MAX_DEF  = 4096;

	// fixed port widths
	localparam int PROC_W     = 11;
	localparam int GRID_W     = 13;
	localparam int SPLIT_W    = 11;
	localparam int COST_W     = 37;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;

	// weight of the surface term in the cost
	localparam int SURFACE_WEIGHT = 100;

	localparam logic [COST_W-1:0] COST_MAX = '1;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GRID_X = 3'd0,
		CFG_GRID_Y = 3'd1,
		CFG_GRID_Z = 3'd2,
		CFG_ACT_X  = 3'd3,
		CFG_ACT_Y  = 3'd4,
		CFG_ACT_Z  = 3'd5
	} cfg_idx_t;

	typedef enum logic [1:0] {
		AXIS_X,
		AXIS_Y,
		AXIS_Z
	} axis_t;

	typedef enum logic [1:0] {
		MUL_XY,
		MUL_VOL,
		MUL_SIDE
	} mul_op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_INIT,
		ST_DIV_X,
		ST_WAIT_X,
		ST_CHK_X,
		ST_DIV_Y,
		ST_WAIT_Y,
		ST_CHK_Y,
		ST_MUL_XY,
		ST_DIV_Z,
		ST_WAIT_Z,
		ST_CHK_Z,
		ST_MUL_VOL,
		ST_MUL_SIDE,
		ST_SUM,
		ST_COST,
		ST_CMP,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic    load;
		logic    div_start;
		axis_t   div_axis;
		logic    mul_en;
		mul_op_t mul_op;
		logic    sum_en;
		logic    cost_en;
		logic    cmp_en;
		logic    force_best;
		logic    enter_y;
		logic    enter_z;
		logic    step_x;
		logic    step_y;
		logic    step_z;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_done;
		logic x_ok;
		logic y_ok;
		logic z_ok;
	} status_t;

endpackage

// ===== sv/gss_div.sv =====
// restoring divider, one quotient bit per cycle
module gss_div #(
	parameter int NW = 14,
	parameter int DW = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quot
);

	localparam int CNTW = $clog2(NW + 1);

	logic            busy_q;
	logic            done_q;
	logic [CNTW-1:0] cnt_q;
	logic [NW-1:0]   num_q;
	logic [DW-1:0]   den_q;
	logic [DW-1:0]   rem_q;

	logic [DW:0] trial;
	logic [DW:0] diff;
	logic        ge;

	// shift in the next numerator bit and try the subtract
	always_comb begin
		trial = {rem_q, num_q[NW-1]};
		diff  = trial - {1'b0, den_q};
		ge    = (trial >= {1'b0, den_q});
	end

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and quotient bits
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
			num_q <= {num_q[NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = num_q;

endmodule

// ===== sv/gss_dp.sv =====
// datapath: loop counters, lengths, cost arithmetic and best split
module gss_dp #(
	parameter int MAX_PROCS = gss_pkg::MAX_PROCS_DEF,
	parameter int GRID_MAX  = gss_pkg::GRID_MAX_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  gss_pkg::cmd_t                  cmd,
	output gss_pkg::status_t               status,
	input  logic [gss_pkg::PROC_W-1:0]     process_count,
	input  logic [gss_pkg::GRID_W-1:0]     grid_size_x,
	input  logic [gss_pkg::GRID_W-1:0]     grid_size_y,
	input  logic [gss_pkg::GRID_W-1:0]     grid_size_z,
	input  logic                           axis_x_active,
	input  logic                           axis_y_active,
	input  logic                           axis_z_active,
	output logic [gss_pkg::SPLIT_W-1:0]    split_x,
	output logic [gss_pkg::SPLIT_W-1:0]    split_y,
	output logic [gss_pkg::SPLIT_W-1:0]    split_z,
	output logic [gss_pkg::SPLIT_W-1:0]    used_processes,
	output logic [gss_pkg::COST_W-1:0]     best_cost
);

	localparam int PW   = $clog2(MAX_PROCS + 1);
	localparam int CNTW = PW + 1;
	localparam int GW   = $clog2(GRID_MAX + 1);
	localparam int NW   = ((GW > CNTW) ? GW : CNTW) + 1;
	localparam int MW   = 3 * GW + 1;
	localparam int SW   = 2 * GW + 2;
	localparam int CW   = ((3 * GW > 2 * GW + 10) ? 3 * GW : 2 * GW + 10) + 1;
	localparam int XW   = CW + gss_pkg::COST_W;

	// request operands
	logic [PW-1:0]   p_q;
	logic [GW-1:0]   sx_q, sy_q, sz_q;
	logic [PW-1:0]   xlim_q, ylim_q, zlim_q;

	// loop counters and running products
	logic [CNTW-1:0] tx_q, ty_q, tz_q;
	logic [CNTW-1:0] txy_q, txyz_q;

	// lengths and cost terms
	logic [GW-1:0]   lx_q, ly_q, lz_q;
	logic [2*GW-1:0] lxy_q;
	logic [3*GW-1:0] vol_q;
	logic [2*GW:0]   side_q;
	logic [SW-1:0]   surf_q;
	logic [CW-1:0]   cost_q;

	// best split so far
	logic [CW-1:0]   best_q;
	logic [CNTW-1:0] bx_q, by_q, bz_q, bused_q;

	logic            div_done;
	logic [NW-1:0]   div_quot;
	logic [NW-1:0]   div_num;
	logic [CNTW-1:0] div_den;
	gss_pkg::axis_t  div_axis_q;

	logic [PW-1:0]   p_sat;
	logic [GW-1:0]   sx_sat, sy_sat, sz_sat;
	logic [PW-1:0]   xlim_d, ylim_d, zlim_d;

	logic [2*GW-1:0] mul_a;
	logic [GW:0]     mul_b;
	logic [MW-1:0]   prod;
	logic [XW-1:0]   cost_ext;

	// saturate the request and the grid sizes, derive the axis limits
	always_comb begin
		p_sat  = (32'(process_count) > 32'(MAX_PROCS)) ? PW'(MAX_PROCS) : PW'(process_count);
		sx_sat = (32'(grid_size_x) > 32'(GRID_MAX)) ? GW'(GRID_MAX) : GW'(grid_size_x);
		sy_sat = (32'(grid_size_y) > 32'(GRID_MAX)) ? GW'(GRID_MAX) : GW'(grid_size_y);
		sz_sat = (32'(grid_size_z) > 32'(GRID_MAX)) ? GW'(GRID_MAX) : GW'(grid_size_z);
		xlim_d = !axis_x_active ? PW'(1) :
			((32'(sx_sat) < 32'(p_sat)) ? PW'(sx_sat) : p_sat);
		ylim_d = !axis_y_active ? PW'(1) :
			((32'(sy_sat) < 32'(p_sat)) ? PW'(sy_sat) : p_sat);
		zlim_d = !axis_z_active ? PW'(1) :
			((32'(sz_sat) < 32'(p_sat)) ? PW'(sz_sat) : p_sat);
	end

	// loop bounds: split within the axis limit and product within the request
	always_comb begin
		status.div_done = div_done;
		status.x_ok     = (tx_q <= CNTW'(xlim_q));
		status.y_ok     = (ty_q <= CNTW'(ylim_q)) && (txy_q <= CNTW'(p_q));
		status.z_ok     = (tz_q <= CNTW'(zlim_q)) && (txyz_q <= CNTW'(p_q));
	end

	// ceiling division operands: (size + split - 1) / split
	always_comb begin
		case (cmd.div_axis)
			gss_pkg::AXIS_X: begin
				div_num = NW'(sx_q) + NW'(tx_q) - NW'(1);
				div_den = tx_q;
			end
			gss_pkg::AXIS_Y: begin
				div_num = NW'(sy_q) + NW'(ty_q) - NW'(1);
				div_den = ty_q;
			end
			gss_pkg::AXIS_Z: begin
				div_num = NW'(sz_q) + NW'(tz_q) - NW'(1);
				div_den = tz_q;
			end
			default: begin
				div_num = '0;
				div_den = CNTW'(1);
			end
		endcase
	end

	gss_div #(
		.NW (NW),
		.DW (CNTW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	// shared multiplier operands
	always_comb begin
		case (cmd.mul_op)
			gss_pkg::MUL_XY: begin
				mul_a = (2*GW)'(lx_q);
				mul_b = (GW+1)'(ly_q);
			end
			gss_pkg::MUL_VOL: begin
				mul_a = lxy_q;
				mul_b = (GW+1)'(lz_q);
			end
			gss_pkg::MUL_SIDE: begin
				mul_a = (2*GW)'(lz_q);
				mul_b = (GW+1)'(lx_q) + (GW+1)'(ly_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		prod = MW'(mul_a) * MW'(mul_b);
	end

	// request load and loop counters
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			p_q    <= p_sat;
			sx_q   <= sx_sat;
			sy_q   <= sy_sat;
			sz_q   <= sz_sat;
			xlim_q <= xlim_d;
			ylim_q <= ylim_d;
			zlim_q <= zlim_d;
			tx_q   <= CNTW'(1);
			ty_q   <= CNTW'(1);
			tz_q   <= CNTW'(1);
			txy_q  <= CNTW'(1);
			txyz_q <= CNTW'(1);
		end else begin
			if (cmd.step_x) begin
				tx_q <= tx_q + CNTW'(1);
			end
			if (cmd.enter_y) begin
				ty_q  <= CNTW'(1);
				txy_q <= tx_q;
			end else if (cmd.step_y) begin
				ty_q  <= ty_q + CNTW'(1);
				txy_q <= txy_q + tx_q;
			end
			if (cmd.enter_z) begin
				tz_q   <= CNTW'(1);
				txyz_q <= txy_q;
			end else if (cmd.step_z) begin
				tz_q   <= tz_q + CNTW'(1);
				txyz_q <= txyz_q + txy_q;
			end
		end
	end

	// lengths from the divider
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			div_axis_q <= cmd.div_axis;
		end
		if (div_done) begin
			case (div_axis_q)
				gss_pkg::AXIS_X: lx_q <= GW'(div_quot);
				gss_pkg::AXIS_Y: ly_q <= GW'(div_quot);
				gss_pkg::AXIS_Z: lz_q <= GW'(div_quot);
				default: ;
			endcase
		end
	end

	// products, surface sum and cost
	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			case (cmd.mul_op)
				gss_pkg::MUL_XY:   lxy_q  <= prod[2*GW-1:0];
				gss_pkg::MUL_VOL:  vol_q  <= prod[3*GW-1:0];
				gss_pkg::MUL_SIDE: side_q <= prod[2*GW:0];
				default: ;
			endcase
		end
		if (cmd.sum_en) begin
			surf_q <= SW'(lxy_q) + SW'(side_q);
		end
		if (cmd.cost_en) begin
			cost_q <= CW'(vol_q) + CW'(surf_q) * CW'(2 * gss_pkg::SURFACE_WEIGHT);
		end
	end

	// keep the first split of least cost
	always_ff @(posedge clk) begin
		if (cmd.cmp_en && (cmd.force_best || (cost_q < best_q))) begin
			best_q  <= cost_q;
			bx_q    <= tx_q;
			by_q    <= ty_q;
			bz_q    <= tz_q;
			bused_q <= txyz_q;
		end
	end

	// result fields, cost saturated to the port width
	assign cost_ext       = XW'(best_q);
	assign best_cost      = (cost_ext > XW'(gss_pkg::COST_MAX)) ? gss_pkg::COST_MAX :
		cost_ext[gss_pkg::COST_W-1:0];
	assign split_x        = gss_pkg::SPLIT_W'(bx_q);
	assign split_y        = gss_pkg::SPLIT_W'(by_q);
	assign split_z        = gss_pkg::SPLIT_W'(bz_q);
	assign used_processes = gss_pkg::SPLIT_W'(bused_q);

endmodule

// ===== sv/gss_ctrl.sv =====
// controller: walks the nested split loops and sequences each trial
module gss_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  gss_pkg::status_t status,
	output gss_pkg::cmd_t    cmd,
	output logic             busy,
	output logic             done
);

	gss_pkg::state_t state_q, state_d;
	logic            init_q;

	// state register; init marks the trial of split one by one by one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gss_pkg::ST_IDLE;
			init_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == gss_pkg::ST_IDLE && start) begin
				init_q <= 1'b1;
			end else if (state_q == gss_pkg::ST_CMP) begin
				init_q <= 1'b0;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			gss_pkg::ST_IDLE:     if (start) state_d = gss_pkg::ST_INIT;
			gss_pkg::ST_INIT:     state_d = gss_pkg::ST_DIV_X;
			gss_pkg::ST_DIV_X:    state_d = gss_pkg::ST_WAIT_X;
			gss_pkg::ST_WAIT_X: begin
				if (status.div_done) begin
					state_d = init_q ? gss_pkg::ST_DIV_Y : gss_pkg::ST_CHK_Y;
				end
			end
			gss_pkg::ST_CHK_X: begin
				state_d = status.x_ok ? gss_pkg::ST_DIV_X : gss_pkg::ST_DONE;
			end
			gss_pkg::ST_DIV_Y:    state_d = gss_pkg::ST_WAIT_Y;
			gss_pkg::ST_WAIT_Y:   if (status.div_done) state_d = gss_pkg::ST_MUL_XY;
			gss_pkg::ST_CHK_Y: begin
				state_d = status.y_ok ? gss_pkg::ST_DIV_Y : gss_pkg::ST_CHK_X;
			end
			gss_pkg::ST_MUL_XY: begin
				state_d = init_q ? gss_pkg::ST_DIV_Z : gss_pkg::ST_CHK_Z;
			end
			gss_pkg::ST_DIV_Z:    state_d = gss_pkg::ST_WAIT_Z;
			gss_pkg::ST_WAIT_Z:   if (status.div_done) state_d = gss_pkg::ST_MUL_VOL;
			gss_pkg::ST_CHK_Z: begin
				state_d = status.z_ok ? gss_pkg::ST_DIV_Z : gss_pkg::ST_CHK_Y;
			end
			gss_pkg::ST_MUL_VOL:  state_d = gss_pkg::ST_MUL_SIDE;
			gss_pkg::ST_MUL_SIDE: state_d = gss_pkg::ST_SUM;
			gss_pkg::ST_SUM:      state_d = gss_pkg::ST_COST;
			gss_pkg::ST_COST:     state_d = gss_pkg::ST_CMP;
			gss_pkg::ST_CMP:      state_d = init_q ? gss_pkg::ST_CHK_X : gss_pkg::ST_CHK_Z;
			gss_pkg::ST_DONE:     state_d = gss_pkg::ST_IDLE;
			default:              state_d = gss_pkg::ST_IDLE;
		endcase
	end

	// commands to the datapath; the request is captured at the accepting edge
	always_comb begin
		cmd          = '0;
		cmd.div_axis = gss_pkg::AXIS_X;
		cmd.mul_op   = gss_pkg::MUL_XY;
		busy         = (state_q != gss_pkg::ST_IDLE);
		done         = 1'b0;
		case (state_q)
			gss_pkg::ST_IDLE:  cmd.load = start;
			gss_pkg::ST_DIV_X: begin
				cmd.div_start = 1'b1;
				cmd.div_axis  = gss_pkg::AXIS_X;
			end
			gss_pkg::ST_CHK_X: cmd.enter_y = status.x_ok;
			gss_pkg::ST_DIV_Y: begin
				cmd.div_start = 1'b1;
				cmd.div_axis  = gss_pkg::AXIS_Y;
			end
			gss_pkg::ST_CHK_Y: cmd.step_x = !status.y_ok;
			gss_pkg::ST_MUL_XY: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_op  = gss_pkg::MUL_XY;
				cmd.enter_z = 1'b1;
			end
			gss_pkg::ST_DIV_Z: begin
				cmd.div_start = 1'b1;
				cmd.div_axis  = gss_pkg::AXIS_Z;
			end
			gss_pkg::ST_CHK_Z: cmd.step_y = !status.z_ok;
			gss_pkg::ST_MUL_VOL: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = gss_pkg::MUL_VOL;
			end
			gss_pkg::ST_MUL_SIDE: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = gss_pkg::MUL_SIDE;
			end
			gss_pkg::ST_SUM:  cmd.sum_en = 1'b1;
			gss_pkg::ST_COST: cmd.cost_en = 1'b1;
			gss_pkg::ST_CMP: begin
				cmd.cmp_en     = 1'b1;
				cmd.force_best = init_q;
				cmd.step_z     = !init_q;
			end
			gss_pkg::ST_DONE: done = 1'b1;
			default: ;
		endcase
	end

endmodule

// ===== sv/grid_split_search.sv =====
// channel   direction  handshake                  payload
// command   in         start, busy                process_count
// result    out        done (one-cycle strobe)    split_x/y/z, used_processes, best_cost
// config    in         cfg_valid, cfg_ready       cfg_index, cfg_data
//
// a word is taken when start is high and busy is low; busy stays high through
// the result strobe. each trial split runs a divide on the bit-serial divider,
// whose numerator width is NW (14 at default sizes), and each x or y step adds
// its own divide and loop checks, so the shared divider sets the request time.
// the receiver cannot stall: done lasts one cycle. reset is asynchronous and
// loads the register defaults.
`include "grid_split_search_defines.svh"

module grid_split_search #(
	parameter int MAX_PROCS = gss_pkg::MAX_PROCS_DEF,
	parameter int GRID_MAX  = gss_pkg::GRID_MAX_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [gss_pkg::PROC_W-1:0]        process_count,
	output logic                              done,
	output logic [gss_pkg::SPLIT_W-1:0]       split_x,
	output logic [gss_pkg::SPLIT_W-1:0]       split_y,
	output logic [gss_pkg::SPLIT_W-1:0]       split_z,
	output logic [gss_pkg::SPLIT_W-1:0]       used_processes,
	output logic [gss_pkg::COST_W-1:0]        best_cost,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [gss_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [gss_pkg::CFG_DATA_W-1:0]    cfg_data
);

	logic [gss_pkg::GRID_W-1:0] grid_x_q, grid_y_q, grid_z_q;
	logic                       act_x_q, act_y_q, act_z_q;

	gss_pkg::cmd_t    cmd;
	gss_pkg::status_t status;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_x_q <= gss_pkg::GRID_W'(1);
			grid_y_q <= gss_pkg::GRID_W'(1);
			grid_z_q <= gss_pkg::GRID_W'(1);
			act_x_q  <= 1'b1;
			act_y_q  <= 1'b0;
			act_z_q  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (gss_pkg::cfg_idx_t'(cfg_index))
				gss_pkg::CFG_GRID_X: grid_x_q <= cfg_data;
				gss_pkg::CFG_GRID_Y: grid_y_q <= cfg_data;
				gss_pkg::CFG_GRID_Z: grid_z_q <= cfg_data;
				gss_pkg::CFG_ACT_X:  act_x_q  <= cfg_data[0];
				gss_pkg::CFG_ACT_Y:  act_y_q  <= cfg_data[0];
				gss_pkg::CFG_ACT_Z:  act_z_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	gss_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	gss_dp #(
		.MAX_PROCS (MAX_PROCS),
		.GRID_MAX  (GRID_MAX)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.process_count  (process_count),
		.grid_size_x    (grid_x_q),
		.grid_size_y    (grid_y_q),
		.grid_size_z    (grid_z_q),
		.axis_x_active  (act_x_q),
		.axis_y_active  (act_y_q),
		.axis_z_active  (act_z_q),
		.split_x        (split_x),
		.split_y        (split_y),
		.split_z        (split_z),
		.used_processes (used_processes),
		.best_cost      (best_cost)
	);

	// checks
	`GSS_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted word did not raise busy")
	`GSS_ASSERT_NEXT(a_done_idle, done, !busy, "block still busy after result strobe")
	`GSS_ASSERT_NOW(a_busy_cause, $rose(busy), $past(start), "busy rose without a start")

endmodule

// ===== sim/grid_split_search_tb.sv =====
`timescale 1ns / 1ps

module grid_split_search_tb;

	localparam int MAX_PROCS = gss_pkg::MAX_PROCS_DEF;
	localparam int GRID_MAX = gss_pkg::GRID_MAX_DEF;
	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLES_PER_TRIAL = 30;
	localparam int TRIAL_CAP = 700;
	localparam int BIG_TRIAL_CAP = 4000;
	localparam int RAND_PHASES = 12;
	localparam int ITEMS_PER_PHASE = 8;

	// indexes past the register list, writes there are dropped
	localparam logic [gss_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [gss_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

	typedef struct {
		logic [gss_pkg::SPLIT_W-1:0] sx;
		logic [gss_pkg::SPLIT_W-1:0] sy;
		logic [gss_pkg::SPLIT_W-1:0] sz;
		logic [gss_pkg::SPLIT_W-1:0] used;
		logic [gss_pkg::COST_W-1:0] cost;
		int trials;
		int steps;
	} split_result_t;

	typedef struct {
		logic [gss_pkg::PROC_W-1:0] pcount;
		bit hold;
	} request_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [gss_pkg::PROC_W-1:0] process_count;
	logic done;
	logic [gss_pkg::SPLIT_W-1:0] split_x;
	logic [gss_pkg::SPLIT_W-1:0] split_y;
	logic [gss_pkg::SPLIT_W-1:0] split_z;
	logic [gss_pkg::SPLIT_W-1:0] used_processes;
	logic [gss_pkg::COST_W-1:0] best_cost;
	logic cfg_valid;
	logic cfg_ready;
	logic [gss_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [gss_pkg::CFG_DATA_W-1:0] cfg_data;

	// local copy of the register file
	logic [gss_pkg::GRID_W-1:0] grid_x;
	logic [gss_pkg::GRID_W-1:0] grid_y;
	logic [gss_pkg::GRID_W-1:0] grid_z;
	logic axis_x_on;
	logic axis_y_on;
	logic axis_z_on;

	request_t request_q[$];
	split_result_t expected_splits[$];
	bit word_taken;
	int sender_idle_pct;
	int mismatch_count;
	longint elapsed;
	longint cycle_limit;

	grid_split_search uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.process_count(process_count),
		.done(done),
		.split_x(split_x),
		.split_y(split_y),
		.split_z(split_z),
		.used_processes(used_processes),
		.best_cost(best_cost),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// worst subdomain volume plus weighted surface
	function automatic longint unsigned subdomain_cost(input longint unsigned sx,
			input longint unsigned sy, input longint unsigned sz,
			input longint unsigned nx, input longint unsigned ny, input longint unsigned nz);
		longint unsigned lx, ly, lz, vol, surf;
		lx = (sx + nx - 1) / nx;
		ly = (sy + ny - 1) / ny;
		lz = (sz + nz - 1) / nz;
		vol = lx * ly * lz;
		surf = 2 * (lx * ly + ly * lz + lx * lz);
		return vol + longint'(gss_pkg::SURFACE_WEIGHT) * surf;
	endfunction

	// exhaustive search over splits, first lowest cost wins
	function automatic split_result_t best_split(input logic [gss_pkg::PROC_W-1:0] pcount);
		longint unsigned p, sx, sy, sz, xlim, ylim, zlim;
		longint unsigned ymax, zmax, tx, ty, tz, c, low, bx, by, bz;
		split_result_t r;
		p = (pcount > MAX_PROCS) ? MAX_PROCS : pcount;
		sx = (grid_x > GRID_MAX) ? GRID_MAX : grid_x;
		sy = (grid_y > GRID_MAX) ? GRID_MAX : grid_y;
		sz = (grid_z > GRID_MAX) ? GRID_MAX : grid_z;
		xlim = !axis_x_on ? 1 : (sx < p) ? sx : p;
		ylim = !axis_y_on ? 1 : (sy < p) ? sy : p;
		zlim = !axis_z_on ? 1 : (sz < p) ? sz : p;
		bx = 1;
		by = 1;
		bz = 1;
		low = subdomain_cost(sx, sy, sz, 1, 1, 1);
		r.trials = 0;
		r.steps = 0;
		for (tx = 1; tx <= xlim; tx++) begin
			r.steps++;
			ymax = p / tx;
			if (ymax > ylim)
				ymax = ylim;
			for (ty = 1; ty <= ymax; ty++) begin
				r.steps++;
				zmax = p / (tx * ty);
				if (zmax > zlim)
					zmax = zlim;
				for (tz = 1; tz <= zmax; tz++) begin
					r.trials++;
					c = subdomain_cost(sx, sy, sz, tx, ty, tz);
					if (c < low) begin
						low = c;
						bx = tx;
						by = ty;
						bz = tz;
					end
				end
			end
		end
		r.sx = bx;
		r.sy = by;
		r.sz = bz;
		r.used = bx * by * bz;
		r.cost = (low > gss_pkg::COST_MAX) ? gss_pkg::COST_MAX : low;
		return r;
	endfunction

	function automatic logic [gss_pkg::PROC_W-1:0] pick_count();
		int r;
		r = $urandom_range(99);
		if (r < 3)
			return '0;
		if (r < 6)
			return $urandom_range(MAX_PROCS + 1, 2047);
		if (r < 60)
			return $urandom_range(1, 32);
		if (r < 85)
			return $urandom_range(33, 256);
		return $urandom_range(257, MAX_PROCS);
	endfunction

	function automatic logic [gss_pkg::GRID_W-1:0] pick_size();
		int r;
		r = $urandom_range(99);
		if (r < 5)
			return '0;
		if (r < 10)
			return $urandom_range(GRID_MAX, 8191);
		if (r < 60)
			return $urandom_range(1, 16);
		if (r < 85)
			return $urandom_range(17, 256);
		return $urandom_range(257, GRID_MAX - 1);
	endfunction

	task automatic check_field(input string label, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", label, want, got);
			mismatch_count++;
		end
	endtask

	// register write, mirrored into the local copy on acceptance
	task automatic write_reg(input logic [gss_pkg::CFG_IDX_W-1:0] idx,
			input logic [gss_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			gss_pkg::CFG_GRID_X: grid_x = data;
			gss_pkg::CFG_GRID_Y: grid_y = data;
			gss_pkg::CFG_GRID_Z: grid_z = data;
			gss_pkg::CFG_ACT_X: axis_x_on = data[0];
			gss_pkg::CFG_ACT_Y: axis_y_on = data[0];
			gss_pkg::CFG_ACT_Z: axis_z_on = data[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// queue one request and widen the timeout by its search length
	task automatic queue_request(input logic [gss_pkg::PROC_W-1:0] pcount, input bit hold);
		split_result_t est;
		request_t req;
		est = best_split(pcount);
		req.pcount = pcount;
		req.hold = hold;
		request_q.push_back(req);
		cycle_limit += 4 * ((est.trials + est.steps + 4) * CYCLES_PER_TRIAL + 100);
	endtask

	task automatic wait_idle();
		while (request_q.size() != 0 || expected_splits.size() != 0 || start || busy)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// command driver, inputs move on the falling edge
	always @(negedge clk) begin
		logic drive;
		if (!start || word_taken) begin
			drive = 1'b0;
			if (request_q.size() != 0 && $urandom_range(99) >= sender_idle_pct)
				drive = !request_q[0].hold || (expected_splits.size() == 0 && !busy);
			if (drive) begin
				process_count <= request_q[0].pcount;
				void'(request_q.pop_front());
			end
			start <= drive;
		end
	end

	// accepted words feed the predictor, results are checked in order
	always @(posedge clk) begin
		split_result_t want;
		if (arst_n) begin
			word_taken = start && !busy;
			if (word_taken)
				expected_splits.push_back(best_split(process_count));
			if (done) begin
				if (expected_splits.size() == 0) begin
					$error("result strobe with no request outstanding");
					mismatch_count++;
				end else begin
					want = expected_splits.pop_front();
					check_field("split_x", want.sx, split_x);
					check_field("split_y", want.sy, split_y);
					check_field("split_z", want.sz, split_z);
					check_field("used_processes", want.used, used_processes);
					check_field("best_cost", want.cost, best_cost);
				end
			end
		end
	end

	// timeout
	initial begin
		elapsed = 0;
		while (elapsed <= cycle_limit) begin
			@(posedge clk);
			elapsed++;
		end
		$display("grid_split_search regression: fail");
		$finish;
	end

	initial begin
		int ph;
		int n;
		int big_left;
		logic [gss_pkg::PROC_W-1:0] pc;
		logic [gss_pkg::CFG_DATA_W-1:0] cdata;
		split_result_t est;

		arst_n = 1'b0;
		start = 1'b0;
		process_count = '0;
		cfg_valid = 1'b0;
		cfg_index = gss_pkg::CFG_GRID_X;
		cfg_data = '0;
		word_taken = 1'b0;
		mismatch_count = 0;
		cycle_limit = 100000;
		sender_idle_pct = 7;
		big_left = 2;
		grid_x = 1;
		grid_y = 1;
		grid_z = 1;
		axis_x_on = 1'b1;
		axis_y_on = 1'b0;
		axis_z_on = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// register defaults: trivial grid, zero and saturated counts
		queue_request(1, 0);
		queue_request('0, 0);
		queue_request('1, 0);
		queue_request(MAX_PROCS, 0);
		wait_idle();

		// oversized x grid clamps to the grid limit, x alone spans all counts
		write_reg(gss_pkg::CFG_GRID_X, '1);
		queue_request(MAX_PROCS, 0);
		queue_request(1, 0);
		queue_request(MAX_PROCS + 1, 0);
		wait_idle();

		// zero sizes on active axes leave the split at one
		write_reg(gss_pkg::CFG_GRID_X, '0);
		write_reg(gss_pkg::CFG_GRID_Y, '0);
		write_reg(gss_pkg::CFG_GRID_Z, 5);
		write_reg(gss_pkg::CFG_ACT_Y, 1);
		write_reg(gss_pkg::CFG_ACT_Z, 1);
		queue_request(7, 0);
		queue_request('1, 0);
		wait_idle();

		// ordinary 3-d search, second request waits for the first result
		write_reg(gss_pkg::CFG_GRID_X, 60);
		write_reg(gss_pkg::CFG_GRID_Y, 45);
		write_reg(gss_pkg::CFG_GRID_Z, 30);
		queue_request(60, 0);
		queue_request(17, 1);
		queue_request(2, 0);
		wait_idle();

		// every axis held, largest grid gives the largest cost
		write_reg(gss_pkg::CFG_ACT_X, 0);
		write_reg(gss_pkg::CFG_ACT_Y, 0);
		write_reg(gss_pkg::CFG_ACT_Z, 0);
		write_reg(gss_pkg::CFG_GRID_X, GRID_MAX);
		write_reg(gss_pkg::CFG_GRID_Y, GRID_MAX);
		write_reg(gss_pkg::CFG_GRID_Z, GRID_MAX);
		write_reg(CFG_SPARE_LO, '1);
		write_reg(CFG_SPARE_HI, '1);
		queue_request(MAX_PROCS, 0);
		queue_request('0, 0);
		wait_idle();

		// largest grid on all three axes
		write_reg(gss_pkg::CFG_ACT_X, 1);
		write_reg(gss_pkg::CFG_ACT_Y, 1);
		write_reg(gss_pkg::CFG_ACT_Z, 1);
		queue_request(64, 0);
		queue_request(1, 0);

		// random register settings, each followed by a batch of requests
		for (ph = 0; ph < RAND_PHASES; ph++) begin
			wait_idle();
			sender_idle_pct = (ph < 4) ? 7 : (ph < 8) ? 59 : 0;
			if ($urandom_range(3) != 0)
				write_reg(gss_pkg::CFG_GRID_X, pick_size());
			if ($urandom_range(3) != 0)
				write_reg(gss_pkg::CFG_GRID_Y, pick_size());
			if ($urandom_range(3) != 0)
				write_reg(gss_pkg::CFG_GRID_Z, pick_size());
			cdata = $urandom;
			if ($urandom_range(3) != 0)
				write_reg(gss_pkg::CFG_ACT_X, cdata);
			cdata = $urandom;
			if ($urandom_range(3) != 0)
				write_reg(gss_pkg::CFG_ACT_Y, cdata);
			cdata = $urandom;
			if ($urandom_range(3) != 0)
				write_reg(gss_pkg::CFG_ACT_Z, cdata);
			cdata = $urandom;
			if ($urandom_range(4) == 0)
				write_reg($urandom_range(1) ? CFG_SPARE_LO : CFG_SPARE_HI, cdata);
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				pc = pick_count();
				est = best_split(pc);
				// long searches are rare, most fall back to small counts
				while (est.trials > TRIAL_CAP
						&& !(big_left > 0 && est.trials <= BIG_TRIAL_CAP)) begin
					pc = $urandom_range(1, 24);
					est = best_split(pc);
				end
				if (est.trials > TRIAL_CAP)
					big_left--;
				queue_request(pc, $urandom_range(19) == 0);
			end
		end
		wait_idle();

		if (mismatch_count == 0)
			$display("grid_split_search regression: pass");
		else
			$display("grid_split_search regression: fail");
		$finish;
	end

endmodule
